@@ hw/rtl/fdg_pkg.sv @@
// ----------------------------------------------------------------------------
// fdg_pkg
// Shared types and codes of the face derivative gather block.
// ----------------------------------------------------------------------------
package fdg_pkg;

  localparam int VALUE_W = 32;

  typedef struct packed {
    logic                      command;
    logic [9:0]                cell_index;
    logic [2:0]                deriv_slot;
    logic signed [VALUE_W-1:0] load_value;
    logic [9:0]                left_cell;
    logic [9:0]                right_cell;
    logic                      upwind_left;
  } in_word_t;

  typedef struct packed {
    logic                      face_side;
    logic [2:0]                out_slot;
    logic signed [VALUE_W-1:0] out_value;
    logic                      last_of_face;
  } out_word_t;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_FACE = 1'b1;

  // configuration register indexes
  localparam logic CFG_DERIVS = 1'b0;
  localparam logic CFG_OP     = 1'b1;

  // face operations
  localparam logic [2:0] OP_UPWIND   = 3'd0;
  localparam logic [2:0] OP_GRADIENT = 3'd1;
  localparam logic [2:0] OP_AVERAGE  = 3'd2;
  localparam logic [2:0] OP_LEFT     = 3'd3;
  localparam logic [2:0] OP_RIGHT    = 3'd4;

  localparam logic [3:0] DERIVS_RESET = 4'd3;
  localparam int         OUT_SLOTS    = 8;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } fdg_state_t;

endpackage

@@ hw/rtl/fdg_store.sv @@
// ----------------------------------------------------------------------------
// fdg_store
// Single-port cell derivative memory with a registered read.
// ----------------------------------------------------------------------------
module fdg_store
  import fdg_pkg::*;
#(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      addr,
  input  logic [VALUE_W-1:0] wdata,
  output logic [VALUE_W-1:0] rdata
);

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/face_derivative_gather_top.sv @@
// ----------------------------------------------------------------------------
// face_derivative_gather_top
// Loads per-cell derivative words into a memory and, per face, streams the
// left and right halves shaped by the configured face operation.
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  input     start, busy, in_word           taken when start && !busy
//  result    out_strobe, out_word           a word per strobe, no stall
//  config    cfg_we, cfg_index, cfg_data    written when cfg_we
//
//  a face issues one memory read per result word, m for each half, m being the
//  derivs register clamped to 1..min(MAX_DERIVS, OUT_SLOTS)
//  each result passes the registered read and the output register; one per cycle
//  synchronous active-low reset clears control and configuration, not memory
//  the result side cannot stall; busy holds off new words during a face
// ----------------------------------------------------------------------------
module face_derivative_gather_top
  import fdg_pkg::*;
#(
  parameter int MAX_CELLS  = 1024,
  parameter int MAX_DERIVS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_strobe,
  output out_word_t out_word,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [3:0] cfg_data
);

  localparam int CW    = $clog2(MAX_CELLS);
  localparam int SW    = (MAX_DERIVS > 1) ? $clog2(MAX_DERIVS) : 1;
  localparam int AW    = CW + SW;
  localparam int DEPTH = MAX_CELLS * (2 ** SW);
  localparam int LIMIT = (MAX_DERIVS < OUT_SLOTS) ? MAX_DERIVS : OUT_SLOTS;

  fdg_state_t state_r, state_nxt;

  logic [3:0]    derivs_r;
  logic [2:0]    op_r;
  logic [3:0]    m_r, m_nxt;
  logic          side_r, side_nxt;
  logic [2:0]    slot_r, slot_nxt;
  logic [CW-1:0] left_r, right_r;
  logic          left_ok_r, right_ok_r, upl_r;

  logic          p1_valid_r, p1_side_r, p1_last_r, p1_zero_r;
  logic [2:0]    p1_slot_r;
  logic          out_strobe_r;
  out_word_t     out_word_r;

  logic               accept, issue, last_issue;
  logic               ld_ok;
  logic [3:0]         m_clamp;
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [VALUE_W-1:0] mem_rdata;
  logic [VALUE_W-1:0] v, r;

  assign accept = start && !busy;
  assign ld_ok  = (17'(in_word.cell_index) < 17'(MAX_CELLS))
               && (6'(in_word.deriv_slot) < 6'(MAX_DERIVS));

  always_comb begin
    if (derivs_r == 4'd0) begin
      m_clamp = 4'd1;
    end else if (derivs_r > 4'(LIMIT)) begin
      m_clamp = 4'(LIMIT);
    end else begin
      m_clamp = derivs_r;
    end
  end

  assign last_issue = side_r && (slot_r == 3'(m_r - 4'd1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_word.command == CMD_FACE) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_issue) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    issue    = 1'b0;
    mem_we   = 1'b0;
    side_nxt = side_r;
    slot_nxt = slot_r;
    m_nxt    = m_r;
    mem_addr = {(side_r ? right_r : left_r), SW'(slot_r)};
    case (state_r)
      ST_IDLE: begin
        side_nxt = 1'b0;
        slot_nxt = 3'd0;
        m_nxt    = m_clamp;
        if (accept && in_word.command == CMD_LOAD) begin
          mem_we   = ld_ok;
          mem_addr = {CW'(in_word.cell_index), SW'(in_word.deriv_slot)};
        end
      end
      ST_RUN: begin
        issue = 1'b1;
        if (slot_r == 3'(m_r - 4'd1)) begin
          side_nxt = 1'b1;
          slot_nxt = 3'd0;
        end else begin
          slot_nxt = slot_r + 3'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      derivs_r   <= DERIVS_RESET;
      op_r       <= OP_UPWIND;
      p1_valid_r <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      p1_valid_r   <= issue;
      out_strobe_r <= p1_valid_r;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DERIVS: derivs_r <= cfg_data;
          CFG_OP:     op_r     <= cfg_data[2:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    side_r <= side_nxt;
    slot_r <= slot_nxt;
    m_r    <= m_nxt;
    if (accept && in_word.command == CMD_FACE) begin
      left_r     <= CW'(in_word.left_cell);
      right_r    <= CW'(in_word.right_cell);
      left_ok_r  <= 17'(in_word.left_cell) < 17'(MAX_CELLS);
      right_ok_r <= 17'(in_word.right_cell) < 17'(MAX_CELLS);
      upl_r      <= in_word.upwind_left;
    end
    p1_side_r <= side_r;
    p1_slot_r <= slot_r;
    p1_last_r <= last_issue;
    p1_zero_r <= side_r ? !right_ok_r : !left_ok_r;
  end

  fdg_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (in_word.load_value),
    .rdata (mem_rdata)
  );

  // shape the word read back for this half
  assign v = p1_zero_r ? '0 : mem_rdata;

  always_comb begin
    case (op_r)
      OP_UPWIND:   r = ((!p1_side_r) == upl_r) ? v : '0;
      OP_GRADIENT: begin
        if (p1_side_r) begin
          r = v;
        end else if (v == {1'b1, {(VALUE_W-1){1'b0}}}) begin
          r = {1'b0, {(VALUE_W-1){1'b1}}};
        end else begin
          r = ~v + 1'b1;
        end
      end
      OP_AVERAGE:  r = {v[VALUE_W-1], v[VALUE_W-1:1]};
      OP_LEFT:     r = p1_side_r ? '0 : v;
      OP_RIGHT:    r = p1_side_r ? v : '0;
      default:     r = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    out_word_r.face_side    <= p1_side_r;
    out_word_r.out_slot     <= p1_slot_r;
    out_word_r.out_value    <= r;
    out_word_r.last_of_face <= p1_last_r;
  end

  // busy covers the read in flight; that configuration stays put until it lands is up to the user
  assign busy       = (state_r == ST_RUN) || p1_valid_r;
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  a_strobe_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(p1_valid_r))
    else $error("result word without a read behind it");

  a_run_is_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> busy)
    else $error("sequencer running while not busy");

  a_last_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_word_r.last_of_face) |-> state_r == ST_IDLE)
    else $error("last word of face while sequencer still running");

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> ({1'b0, slot_r} < m_r))
    else $error("slot counter beyond derivative count");

endmodule
